// ----- rtl/bis_pkg.sv -----
package bis_pkg;

  localparam int FRAC_BITS  = 10;
  localparam int FRAC_MAX   = (1 << FRAC_BITS) - 1;
  localparam int ADDR_W     = 16;
  localparam int SRC_DEPTH  = 1 << ADDR_W;
  localparam int PIX_W      = 32;
  localparam int CH_W       = 8;
  localparam int NCH        = PIX_W / CH_W;
  localparam int COORD_W    = 10;
  localparam int SRC_DIM_W  = 9;
  localparam int DST_DIM_W  = 11;
  localparam int STEP_W     = SRC_DIM_W + FRAC_BITS;
  localparam int POS_W      = STEP_W + COORD_W;
  localparam int WT_W       = 8;
  localparam int WT_PROD_W  = 2 * FRAC_BITS;
  localparam int ACC_W      = 2 * CH_W + 2;
  localparam int NBR        = 4;
  localparam int NBR_W      = $clog2(NBR);
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH  = 2;
  localparam int RES_W      = $clog2(OUT_DEPTH + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DST_DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

  localparam logic [SRC_DIM_W-1:0] SRC_DIM_RESET = 9'd256;
  localparam logic [DST_DIM_W-1:0] DST_DIM_RESET = 11'd256;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // s_axis_tdata layout, lowest bit first
  localparam int IN_ADDR_LSB  = 0;
  localparam int IN_PIX_LSB   = IN_ADDR_LSB + ADDR_W;
  localparam int IN_X_LSB     = IN_PIX_LSB + PIX_W;
  localparam int IN_Y_LSB     = IN_X_LSB + COORD_W;
  localparam int IN_USED_W    = IN_Y_LSB + COORD_W;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  typedef struct packed {
    logic                            kind;
    logic [NBR-1:0][ADDR_W-1:0]      addr;
    logic [PIX_W-1:0]                pixel;
    logic [NBR-1:0][WT_W-1:0]        wt;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/bis_ram.sv -----
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- rtl/bis_front.sv -----
module bis_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [bis_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                           s_axis_tuser,
  output logic                           push,
  output bis_pkg::cmd_t                  push_cmd,
  input  bis_pkg::q_stat_t               q_stat,
  output logic                           busy
);
  import bis_pkg::*;

  localparam int CNT_W = $clog2(STEP_W + 1);

  logic [SRC_DIM_W-1:0] src_width;
  logic [SRC_DIM_W-1:0] src_height;
  logic [DST_DIM_W-1:0] dst_width;
  logic [DST_DIM_W-1:0] dst_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= SRC_DIM_RESET;
      src_height <= SRC_DIM_RESET;
      dst_width  <= DST_DIM_RESET;
      dst_height <= DST_DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_width  <= cfg_wdata[SRC_DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg_wdata[SRC_DIM_W-1:0];
        REG_DST_WIDTH:  dst_width  <= cfg_wdata[DST_DIM_W-1:0];
        REG_DST_HEIGHT: dst_height <= cfg_wdata[DST_DIM_W-1:0];
      endcase
    end
  end

  // step divider: one quotient bit per cycle for both axes
  logic              div_start;
  logic [CNT_W-1:0]  div_cnt;
  logic [STEP_W-1:0] nx, ny;
  logic [DST_DIM_W-1:0] rx, ry, dvx, dvy;
  logic [STEP_W-1:0] dx, dy;
  logic [DST_DIM_W:0] rx_sh, ry_sh, rx_sub, ry_sub;
  logic               x_ge, y_ge;
  logic [STEP_W-1:0] nx_next, ny_next;

  always_comb begin
    rx_sh   = {rx, nx[STEP_W-1]};
    ry_sh   = {ry, ny[STEP_W-1]};
    x_ge    = rx_sh >= {1'b0, dvx};
    y_ge    = ry_sh >= {1'b0, dvy};
    rx_sub  = x_ge ? rx_sh - {1'b0, dvx} : rx_sh;
    ry_sub  = y_ge ? ry_sh - {1'b0, dvy} : ry_sh;
    nx_next = {nx[STEP_W-2:0], x_ge};
    ny_next = {ny[STEP_W-2:0], y_ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_start <= 1'b1;
      div_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        div_start <= 1'b1;
      end else if (div_start) begin
        div_start <= 1'b0;
      end
      if (div_start) begin
        div_cnt <= CNT_W'(STEP_W);
      end else if (div_cnt != '0) begin
        div_cnt <= div_cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      nx  <= {src_width, {FRAC_BITS{1'b0}}};
      ny  <= {src_height, {FRAC_BITS{1'b0}}};
      rx  <= '0;
      ry  <= '0;
      dvx <= (dst_width == '0) ? DST_DIM_W'(1) : dst_width;
      dvy <= (dst_height == '0) ? DST_DIM_W'(1) : dst_height;
    end else if (div_cnt != '0) begin
      nx <= nx_next;
      ny <= ny_next;
      rx <= rx_sub[DST_DIM_W-1:0];
      ry <= ry_sub[DST_DIM_W-1:0];
      if (div_cnt == CNT_W'(1)) begin
        dx <= nx_next;
        dy <= ny_next;
      end
    end
  end

  assign busy = div_start || (div_cnt != '0);

  // coordinate pipeline
  logic adv;
  logic s3_valid;
  cmd_t s3_cmd;

  assign adv           = !s3_valid || !q_stat.full;
  assign s_axis_tready = adv && !busy;
  assign push          = s3_valid && !q_stat.full;
  assign push_cmd      = s3_cmd;

  logic [COORD_W-1:0] in_x, in_y;
  assign in_x = s_axis_tdata[IN_X_LSB +: COORD_W];
  assign in_y = s_axis_tdata[IN_Y_LSB +: COORD_W];

  logic              s1_valid, s1_kind;
  logic [POS_W-1:0]  s1_su, s1_sv;
  logic [ADDR_W-1:0] s1_addr;
  logic [PIX_W-1:0]  s1_pixel;

  logic              s2_valid, s2_kind;
  logic [ADDR_W-1:0] s2_col, s2_rowp, s2_addr;
  logic              s2_sx, s2_sy;
  logic [NBR-1:0][WT_W-1:0] s2_wt;
  logic [PIX_W-1:0]  s2_pixel;

  logic [FRAC_BITS-1:0] fu, fv, fuc, fvc;
  logic [WT_PROD_W-1:0] p0, p1, p2, p3;
  logic [ADDR_W+SRC_DIM_W-1:0] row_prod;
  logic [POS_W:0]       sum_x, sum_y;
  logic [STEP_W-1:0]    lim_x, lim_y;
  logic                 sx, sy;
  logic [NBR-1:0][WT_W-1:0] wt;

  always_comb begin
    fu  = s1_su[FRAC_BITS-1:0];
    fv  = s1_sv[FRAC_BITS-1:0];
    fuc = FRAC_BITS'(FRAC_MAX) - fu;
    fvc = FRAC_BITS'(FRAC_MAX) - fv;
    p0  = {{FRAC_BITS{1'b0}}, fuc} * {{FRAC_BITS{1'b0}}, fvc};
    p1  = {{FRAC_BITS{1'b0}}, fu} * {{FRAC_BITS{1'b0}}, fvc};
    p2  = {{FRAC_BITS{1'b0}}, fuc} * {{FRAC_BITS{1'b0}}, fv};
    p3  = {{FRAC_BITS{1'b0}}, fu} * {{FRAC_BITS{1'b0}}, fv};
    wt[0] = p0[WT_PROD_W-1 -: WT_W];
    wt[1] = p1[WT_PROD_W-1 -: WT_W];
    wt[2] = p2[WT_PROD_W-1 -: WT_W];
    wt[3] = p3[WT_PROD_W-1 -: WT_W];
    row_prod = {{SRC_DIM_W{1'b0}}, s1_sv[FRAC_BITS +: ADDR_W]}
             * {{ADDR_W{1'b0}}, src_width};
    sum_x = {1'b0, s1_su} + {{(POS_W+1-STEP_W){1'b0}}, dx};
    sum_y = {1'b0, s1_sv} + {{(POS_W+1-STEP_W){1'b0}}, dy};
    lim_x = {src_width - 1'b1, {FRAC_BITS{1'b0}}};
    lim_y = {src_height - 1'b1, {FRAC_BITS{1'b0}}};
    sx = (src_width != '0) && (sum_x <= {{(POS_W+1-STEP_W){1'b0}}, lim_x});
    sy = (src_height != '0) && (sum_y <= {{(POS_W+1-STEP_W){1'b0}}, lim_y});
  end

  logic [ADDR_W-1:0] base, ystep;
  cmd_t              s3_next;

  always_comb begin
    base  = s2_col + s2_rowp;
    ystep = s2_sy ? {{(ADDR_W-SRC_DIM_W){1'b0}}, src_width} : '0;
    s3_next.kind    = s2_kind;
    s3_next.pixel   = s2_pixel;
    s3_next.wt      = s2_wt;
    s3_next.addr[0] = (s2_kind == REQ_LOAD) ? s2_addr : base;
    s3_next.addr[1] = base + {{(ADDR_W-1){1'b0}}, s2_sx};
    s3_next.addr[2] = base + ystep;
    s3_next.addr[3] = base + ystep + {{(ADDR_W-1){1'b0}}, s2_sx};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_axis_tvalid && s_axis_tready;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind  <= s_axis_tuser;
      s1_addr  <= s_axis_tdata[IN_ADDR_LSB +: ADDR_W];
      s1_pixel <= s_axis_tdata[IN_PIX_LSB +: PIX_W];
      s1_su    <= {{(POS_W-COORD_W){1'b0}}, in_x} * {{(POS_W-STEP_W){1'b0}}, dx};
      s1_sv    <= {{(POS_W-COORD_W){1'b0}}, in_y} * {{(POS_W-STEP_W){1'b0}}, dy};

      s2_kind  <= s1_kind;
      s2_addr  <= s1_addr;
      s2_pixel <= s1_pixel;
      s2_col   <= s1_su[FRAC_BITS +: ADDR_W];
      s2_rowp  <= row_prod[ADDR_W-1:0];
      s2_sx    <= sx;
      s2_sy    <= sy;
      s2_wt    <= wt;

      s3_cmd   <= s3_next;
    end
  end

endmodule

// ----- rtl/bis_queue.sv -----
module bis_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  bis_pkg::cmd_t    push_cmd,
  input  logic             pop,
  output bis_pkg::cmd_t    head,
  output bis_pkg::q_stat_t q_stat
);
  import bis_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wp, rp;
  logic [CNT_W-1:0] cnt;

  assign head         = slots[rp];
  assign q_stat.full  = cnt == CNT_W'(DEPTH);
  assign q_stat.empty = cnt == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == PTR_W'(DEPTH - 1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == PTR_W'(DEPTH - 1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_cmd;
    end
  end

endmodule

// ----- rtl/bis_back.sv -----
module bis_back (
  input  logic                      clk,
  input  logic                      rst,
  input  bis_pkg::cmd_t             head,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [bis_pkg::PIX_W-1:0] m_axis_tdata
);
  import bis_pkg::*;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_rdata;

  bis_ram #(
    .WIDTH (PIX_W),
    .DEPTH (SRC_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (head.pixel),
    .rdata (ram_rdata)
  );

  logic [NBR_W-1:0] k;
  logic             is_load, go, issue;
  logic [RES_W-1:0] reserved;
  logic             rd_valid;
  logic [NBR_W-1:0] rd_k;
  logic [WT_W-1:0]  rd_w;

  always_comb begin
    is_load  = head.kind == REQ_LOAD;
    go       = !q_empty && (is_load || k != '0 || reserved < RES_W'(OUT_DEPTH));
    ram_we   = go && is_load;
    ram_addr = is_load ? head.addr[0] : head.addr[k];
    issue    = go && !is_load;
    pop      = go && (is_load || k == NBR_W'(NBR - 1));
  end

  // blend one neighbour per cycle while reads are issued; issue waits on an empty queue or a full output buffer
  logic [NCH-1:0][ACC_W-1:0] acc, acc_next;
  logic [PIX_W-1:0]          res;
  logic [2*CH_W-1:0]         prod [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      prod[c]     = {{CH_W{1'b0}}, ram_rdata[c*CH_W +: CH_W]} * {{CH_W{1'b0}}, rd_w};
      acc_next[c] = ((rd_k == '0) ? '0 : acc[c])
                  + {{(ACC_W-2*CH_W){1'b0}}, prod[c]};
      res[c*CH_W +: CH_W] = acc_next[c][CH_W +: CH_W];
    end
  end

  logic             ob_push, m_fire;
  logic [PIX_W-1:0] ob [OUT_DEPTH];
  logic             wp, rp;
  logic [RES_W-1:0] ob_cnt;

  assign ob_push       = rd_valid && (rd_k == NBR_W'(NBR - 1));
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = ob_cnt != '0;
  assign m_axis_tdata  = ob[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      rd_valid <= 1'b0;
      reserved <= '0;
      ob_cnt   <= '0;
      wp       <= 1'b0;
      rp       <= 1'b0;
    end else begin
      rd_valid <= issue;
      if (issue) begin
        k <= k + 1'b1;
      end
      reserved <= reserved + {{(RES_W-1){1'b0}}, issue && (k == '0)}
                           - {{(RES_W-1){1'b0}}, m_fire};
      ob_cnt   <= ob_cnt + {{(RES_W-1){1'b0}}, ob_push}
                         - {{(RES_W-1){1'b0}}, m_fire};
      if (ob_push) begin
        wp <= ~wp;
      end
      if (m_fire) begin
        rp <= ~rp;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_k <= k;
    rd_w <= head.wt[k];
    if (rd_valid) begin
      acc <= acc_next;
    end
    if (ob_push) begin
      ob[wp] <= res;
    end
  end

endmodule

// ----- rtl/bilinear_image_scaler_top.sv -----
// An accepted query passes s1, s2, s3, the command queue, its four neighbour reads and the
// output buffer before its pixel shows on m_axis; loads leave no output. Queries are bounded
// by their reads on the single port of the source store, a load uses that port once, and
// new queries enter while earlier ones are still read. Reset: synchronous, active high;
// registers return to 256 and the step divider then runs with s_axis_tready low. Every
// config write reruns it the same way. The source store is not cleared by reset.
module bilinear_image_scaler_top #(
  parameter int QUEUE_DEPTH = bis_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bis_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // src_addr[15:0], src_pixel[47:16], dst_x[57:48], dst_y[67:58], zero fill
  input  logic [bis_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // out_pixel[31:0]
  output logic [bis_pkg::PIX_W-1:0]      m_axis_tdata
);
  import bis_pkg::*;

  logic    push, pop, front_busy;
  cmd_t    push_cmd, head;
  q_stat_t q_stat;

  bis_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_stat        (q_stat),
    .busy          (front_busy)
  );

  bis_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  bis_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_empty       (q_stat.empty),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |-> !front_busy)
    else $error("word accepted while step divider busy");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("queue pushed while full");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!m_axis_tvalid && !s_axis_tready))
    else $error("ports active right after reset");

endmodule
